// File: hw/rtl/sedge_pkg.sv
// Shared types and constants for the Sobel edge threshold block.
// No dependencies; every other file of the block imports this package.
package sedge_pkg;

    localparam int PIX_W  = 8;      // grey pixel width
    localparam int GRAD_W = 11;     // signed Sobel gradient, |g| <= 1020
    localparam int SQ_W   = 20;     // one squared gradient
    localparam int MAG_W  = 22;     // squared magnitude and squared threshold
    localparam int THR_W  = 11;     // threshold register
    localparam int WREG_W = 11;     // width register
    localparam int HREG_W = 13;     // height register, also row counter
    localparam int CFG_D_W = 13;    // config write data
    localparam int CFG_I_W = 2;     // config register index

    localparam logic [HREG_W-1:0] HEIGHT_LIMIT = 13'd4096;
    localparam logic [PIX_W-1:0]  EDGE_CODE    = 8'd0;
    localparam logic [PIX_W-1:0]  PLAIN_CODE   = 8'd255;

    typedef enum logic [CFG_I_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_THRESH = 2'd2
    } t_cfg_idx;

    // Position of the centre pixel that an input item completes.
    typedef struct packed {
        logic have;      // item completes a centre pixel
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;      // centre is the final pixel of the frame
    } t_pos;

    // 3x3 window, row major, column 2 newest.
    typedef logic [8:0][PIX_W-1:0] t_win;

endpackage

// File: hw/rtl/sobel_edge_threshold.sv
// Top level of the streaming 3x3 Sobel edge detector with threshold.
// Depends on sedge_pkg, sedge_window, sedge_gradient and sedge_threshold.
//
// Grey pixels enter in raster order, one per unstalled clock. Each item is
// taken as the bottom-right tap of a 3x3 window whose centre lies one row and
// one pixel back; both Sobel gradients are formed with zero padding at every
// image border and the pixel is marked an edge (0) when gx^2+gy^2 reaches
// edge_threshold^2, else plain (255). The first image_width+1 items of a
// frame give no result; after the image_width*image_height pixels the host
// sends image_width+1 flush items (tuser set, taken as zero pixels) to bring
// out the rest, and tlast marks the final result of the frame, after which
// the next item starts a new frame. The block takes one item per clock, set
// by the single read and write port of each line store, while the results
// are taken; a result passes the store read, window, gradients, squares and
// compare registers. The line stores are not cleared after reset: the border
// padding masks every tap that could see stale contents. Writing image_width
// or image_height restarts the frame; write registers only while idle.
module sobel_edge_threshold import sedge_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input pixels
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]         s_axis_tuser,   // [0] is_flush
    // results
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [7:0] edge_value
    output logic               m_axis_tlast,   // frame_last
    // register writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_I_W-1:0] i_cfg_index,
    input  logic [CFG_D_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int UW_W  = $clog2(MAX_WIDTH + 1);

    // configuration
    logic [WREG_W-1:0] r_width;
    logic [HREG_W-1:0] r_height;
    logic [THR_W-1:0]  r_thr;
    logic [MAG_W-1:0]  r_thr_sq;

    // position of the next input item, flush items included
    logic [COL_W-1:0]  r_col;
    logic [HREG_W-1:0] r_row;
    logic [COL_W-1:0]  n_col;
    logic [HREG_W-1:0] n_row;

    logic [UW_W-1:0]   w;
    logic [HREG_W-1:0] h;
    logic [UW_W-1:0]   c_ext;
    logic [UW_W-1:0]   col_inc;
    logic [UW_W-1:0]   cc;
    logic [HREG_W-1:0] cr;
    logic              col_nz;
    t_pos              pos;
    logic              s_accept;
    logic              cfg_write;
    logic              restart;

    logic              win_valid, win_ready;
    t_win              win;
    t_pos              win_pos;
    logic              grad_valid, grad_ready;
    logic signed [GRAD_W-1:0] gx, gy;
    logic              grad_last;
    logic [PIX_W-1:0]  px;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign s_accept    = s_axis_tvalid && s_axis_tready;
    assign px          = s_axis_tuser[0] ? '0 : s_axis_tdata;

    // clamp the sizes in use
    always_comb begin
        if (r_width == '0) begin
            w = UW_W'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w = UW_W'(MAX_WIDTH);
        end else begin
            w = UW_W'(r_width);
        end
        if (r_height == '0) begin
            h = HREG_W'(1);
        end else if (r_height > HEIGHT_LIMIT) begin
            h = HEIGHT_LIMIT;
        end else begin
            h = r_height;
        end
    end

    // centre pixel completed by this item and its border flags
    always_comb begin
        c_ext        = UW_W'(r_col);
        col_nz       = (r_col != '0);
        pos.have     = (r_row >= HREG_W'(2)) || ((r_row == HREG_W'(1)) && col_nz);
        cr           = col_nz ? r_row - HREG_W'(1) : r_row - HREG_W'(2);
        cc           = col_nz ? c_ext - UW_W'(1) : w - UW_W'(1);
        pos.top_ok   = (cr != '0);
        pos.bot_ok   = (cr < h - HREG_W'(1));
        pos.left_ok  = (cc != '0);
        pos.right_ok = (cc < w - UW_W'(1));
        pos.last     = (cr == h - HREG_W'(1)) && (cc == w - UW_W'(1));
    end

    // advance the raster position; wrap after the final result of a frame
    always_comb begin
        col_inc = c_ext + UW_W'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (s_accept) begin
            if (col_inc >= w) begin
                n_col = '0;
                n_row = r_row + HREG_W'(1);
            end else begin
                n_col = COL_W'(col_inc);
            end
            if (pos.have && pos.last) begin
                n_col = '0;
                n_row = '0;
            end
        end
    end

    assign restart = cfg_write &&
                     (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WREG_W'(640);
            r_height <= HREG_W'(480);
            r_thr    <= THR_W'(2);
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (cfg_write) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data[WREG_W-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[HREG_W-1:0];
                    CFG_THRESH: r_thr    <= i_cfg_data[THR_W-1:0];
                    default:    ;
                endcase
            end
            // a size write restarts the frame
            if (restart) begin
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // squared threshold, settled long before an item reaches the compare
    always_ff @(posedge i_clk) begin
        r_thr_sq <= MAG_W'(r_thr) * MAG_W'(r_thr);
    end

    sedge_window #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_px    (px),
        .i_col   (r_col),
        .i_pos   (pos),
        .o_valid (win_valid),
        .i_ready (win_ready),
        .o_win   (win),
        .o_pos   (win_pos)
    );

    sedge_gradient u_gradient (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (win_valid),
        .o_ready (win_ready),
        .i_win   (win),
        .i_pos   (win_pos),
        .o_valid (grad_valid),
        .i_ready (grad_ready),
        .o_gx    (gx),
        .o_gy    (gy),
        .o_last  (grad_last)
    );

    sedge_threshold u_threshold (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (grad_valid),
        .o_ready      (grad_ready),
        .i_gx         (gx),
        .i_gy         (gy),
        .i_last       (grad_last),
        .i_thr_sq     (r_thr_sq),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_edge_value (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule

// File: hw/rtl/sedge_window.sv
// Line stores and 3x3 window of the Sobel edge threshold block.
// Depends on sedge_pkg.
module sedge_window import sedge_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_px,
    input  logic [COL_W-1:0] i_col,
    input  t_pos             i_pos,
    output logic             o_valid,
    input  logic             i_ready,
    output t_win             o_win,
    output t_pos             o_pos
);

    logic [PIX_W-1:0] mem_up  [MAX_WIDTH];
    logic [PIX_W-1:0] mem_mid [MAX_WIDTH];

    // stage 1: store read data
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_px;
    logic [COL_W-1:0] r_s1_col;
    t_pos             r_s1_pos;
    logic [PIX_W-1:0] r_rd_up;
    logic [PIX_W-1:0] r_rd_mid;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_up;
    logic [PIX_W-1:0] r_fwd_mid;

    // stage 2: window
    logic             r_s2_valid;
    t_win             r_win;
    t_pos             r_s2_pos;

    logic             s2_ready;
    logic             s1_adv;
    logic             accept;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;

    assign s2_ready = !r_s2_valid || !r_s2_pos.have || i_ready;
    assign s1_adv   = r_s1_valid && s2_ready;
    assign o_ready  = !r_s1_valid || s2_ready;
    assign accept   = i_valid && o_ready;

    // a write and a read of the same column on one edge (one-pixel rows)
    assign up  = r_fwd ? r_fwd_up  : r_rd_up;
    assign mid = r_fwd ? r_fwd_mid : r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            mem_up[r_s1_col]  <= mid;
            mem_mid[r_s1_col] <= r_s1_px;
        end
        if (accept) begin
            r_rd_up   <= mem_up[i_col];
            r_rd_mid  <= mem_mid[i_col];
            r_fwd     <= s1_adv && (r_s1_col == i_col);
            r_fwd_up  <= mid;
            r_fwd_mid <= r_s1_px;
            r_s1_px   <= i_px;
            r_s1_col  <= i_col;
            r_s1_pos  <= i_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[2] <= up;
            r_win[5] <= mid;
            r_win[8] <= r_s1_px;
            r_s2_pos <= r_s1_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= s1_adv;
            end
        end
    end

    // items that complete no centre pixel drop here
    assign o_valid = r_s2_valid && r_s2_pos.have;
    assign o_win   = r_win;
    assign o_pos   = r_s2_pos;

endmodule

// File: hw/rtl/sedge_gradient.sv
// Padded Sobel gradients gx and gy of the Sobel edge threshold block.
// Depends on sedge_pkg.
module sedge_gradient import sedge_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_win                     i_win,
    input  t_pos                     i_pos,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [GRAD_W-1:0] o_gx,
    output logic signed [GRAD_W-1:0] o_gy,
    output logic                     o_last
);

    logic                     r_valid;
    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;
    logic                     r_last;

    logic [8:0][GRAD_W-1:0] t;
    logic [GRAD_W-1:0]      gx_pos, gx_neg, gy_pos, gy_neg;

    // zero the taps that fall outside the image
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            t[k] = GRAD_W'(i_win[k]);
            if ((k < 3 && !i_pos.top_ok) || (k > 5 && !i_pos.bot_ok) ||
                (k % 3 == 0 && !i_pos.left_ok) || (k % 3 == 2 && !i_pos.right_ok)) begin
                t[k] = '0;
            end
        end
        gx_pos = t[2] + (t[5] << 1) + t[8];
        gx_neg = t[0] + (t[3] << 1) + t[6];
        gy_pos = t[6] + (t[7] << 1) + t[8];
        gy_neg = t[0] + (t[1] << 1) + t[2];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_gx   <= $signed(gx_pos - gx_neg);
            r_gy   <= $signed(gy_pos - gy_neg);
            r_last <= i_pos.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_gx    = r_gx;
    assign o_gy    = r_gy;
    assign o_last  = r_last;

endmodule

// File: hw/rtl/sedge_threshold.sv
// Squared magnitude and threshold compare of the Sobel edge threshold block.
// Depends on sedge_pkg; holds the result register.
module sedge_threshold import sedge_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [GRAD_W-1:0] i_gx,
    input  logic signed [GRAD_W-1:0] i_gy,
    input  logic                     i_last,
    input  logic [MAG_W-1:0]         i_thr_sq,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [PIX_W-1:0]         o_edge_value,
    output logic                     o_last
);

    logic                     r_sq_valid;
    logic [SQ_W-1:0]          r_sq_x;
    logic [SQ_W-1:0]          r_sq_y;
    logic                     r_sq_last;
    logic                     r_out_valid;
    logic [PIX_W-1:0]         r_edge_value;
    logic                     r_out_last;

    logic signed [2*GRAD_W-1:0] prod_x;
    logic signed [2*GRAD_W-1:0] prod_y;
    logic [MAG_W-1:0]           mag_sq;
    logic                       out_ready;
    logic                       sq_ready;

    assign prod_x    = i_gx * i_gx;
    assign prod_y    = i_gy * i_gy;
    assign mag_sq    = MAG_W'(r_sq_x) + MAG_W'(r_sq_y);
    assign out_ready = !r_out_valid || i_ready;
    assign sq_ready  = !r_sq_valid || out_ready;
    assign o_ready   = sq_ready;

    always_ff @(posedge i_clk) begin
        if (i_valid && sq_ready) begin
            r_sq_x    <= prod_x[SQ_W-1:0];
            r_sq_y    <= prod_y[SQ_W-1:0];
            r_sq_last <= i_last;
        end
        if (r_sq_valid && out_ready) begin
            r_edge_value <= (mag_sq >= i_thr_sq) ? EDGE_CODE : PLAIN_CODE;
            r_out_last   <= r_sq_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (sq_ready) begin
                r_sq_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_sq_valid;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_edge_value = r_edge_value;
    assign o_last       = r_out_last;

endmodule

// File: hw/rtl/sedge_port_check.sv
// Port-level checks for the Sobel edge threshold block, bound to its top level.
// Depends on sedge_pkg and sobel_edge_threshold.
module sedge_port_check import sedge_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // only the two result codes ever leave
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata == EDGE_CODE || m_axis_tdata == PLAIN_CODE))
        else $error("result code other than edge or plain");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed or dropped");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind sobel_edge_threshold sedge_port_check u_port_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_sobel_edge_threshold.sv
// Self-checking testbench for sobel_edge_threshold: pixel stream in, edge map out.
// Depends on sedge_pkg and the block's RTL; a scoreboard class predicts every result.
`timescale 1ns / 100ps

module tb_sobel_edge_threshold;
    import sedge_pkg::*;

    localparam int MAX_W = 1024;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS = 430;
    localparam logic [CFG_I_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } t_edge_result;

    // Sobel predictor and ordered store of the edge results still owed.
    class edge_scoreboard;
        logic [PIX_W-1:0]  upper_row [MAX_W];
        logic [PIX_W-1:0]  middle_row [MAX_W];
        logic [PIX_W-1:0]  win [9];
        int unsigned       col_pos;
        int unsigned       row_pos;
        logic [WREG_W-1:0] width_reg;
        logic [HREG_W-1:0] height_reg;
        logic [THR_W-1:0]  thresh_reg;
        t_edge_result      pending_edges [$];
        int                errors;
        int                seen;

        function new();
            foreach (upper_row[i]) begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            col_pos = 0;
            row_pos = 0;
            width_reg = 11'd640;
            height_reg = 13'd480;
            thresh_reg = 11'd2;
            errors = 0;
            seen = 0;
        endfunction

        function int unsigned used_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_W) return MAX_W;
            return int'(width_reg);
        endfunction

        function int unsigned used_height();
            if (height_reg == 0) return 1;
            if (height_reg > HEIGHT_LIMIT) return int'(HEIGHT_LIMIT);
            return int'(height_reg);
        endfunction

        function int pending();
            return pending_edges.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void write_reg(logic [CFG_I_W-1:0] idx, logic [CFG_D_W-1:0] data);
            case (idx)
                CFG_WIDTH: begin
                    width_reg = data[WREG_W-1:0];
                    col_pos = 0;
                    row_pos = 0;
                end
                CFG_HEIGHT: begin
                    height_reg = data[HREG_W-1:0];
                    col_pos = 0;
                    row_pos = 0;
                end
                CFG_THRESH: thresh_reg = data[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // Window tap, zero outside the image.
        function int tap(int r, int c, bit top_ok, bit bot_ok, bit left_ok, bit right_ok);
            if (r == 0 && !top_ok) return 0;
            if (r == 2 && !bot_ok) return 0;
            if (c == 0 && !left_ok) return 0;
            if (c == 2 && !right_ok) return 0;
            return int'(win[r*3+c]);
        endfunction

        // Advance the window by one accepted pixel and queue the result it completes.
        function void note_pixel(logic [PIX_W-1:0] pixel, logic is_flush);
            int unsigned w, h, c, r, cr, cc;
            logic [PIX_W-1:0] px, up, mid;
            bit have, top_ok, bot_ok, left_ok, right_ok;
            int gx, gy, mag2, thr2;
            t_edge_result res;

            w = used_width();
            h = used_height();
            px = is_flush ? '0 : pixel;
            c = col_pos;
            r = row_pos;
            cr = 0;
            cc = 0;
            if (c >= w) c = 0;
            up = upper_row[c];
            mid = middle_row[c];
            upper_row[c] = mid;
            middle_row[c] = px;
            for (int k = 0; k < 3; k++) begin
                win[k*3+0] = win[k*3+1];
                win[k*3+1] = win[k*3+2];
            end
            win[2] = up;
            win[5] = mid;
            win[8] = px;

            have = (r >= 2) || (r == 1 && c >= 1);
            if (have) begin
                if (c >= 1) begin
                    cr = r - 1;
                    cc = c - 1;
                end else begin
                    cr = r - 2;
                    cc = w - 1;
                end
            end
            c++;
            if (c >= w) begin
                c = 0;
                r++;
            end
            col_pos = c;
            row_pos = r;
            if (!have) return;

            top_ok = cr > 0;
            bot_ok = cr + 1 < h;
            left_ok = cc > 0;
            right_ok = cc + 1 < w;
            gx = (tap(0, 2, top_ok, bot_ok, left_ok, right_ok)
                  + 2 * tap(1, 2, top_ok, bot_ok, left_ok, right_ok)
                  + tap(2, 2, top_ok, bot_ok, left_ok, right_ok))
               - (tap(0, 0, top_ok, bot_ok, left_ok, right_ok)
                  + 2 * tap(1, 0, top_ok, bot_ok, left_ok, right_ok)
                  + tap(2, 0, top_ok, bot_ok, left_ok, right_ok));
            gy = (tap(2, 0, top_ok, bot_ok, left_ok, right_ok)
                  + 2 * tap(2, 1, top_ok, bot_ok, left_ok, right_ok)
                  + tap(2, 2, top_ok, bot_ok, left_ok, right_ok))
               - (tap(0, 0, top_ok, bot_ok, left_ok, right_ok)
                  + 2 * tap(0, 1, top_ok, bot_ok, left_ok, right_ok)
                  + tap(0, 2, top_ok, bot_ok, left_ok, right_ok));
            mag2 = gx * gx + gy * gy;
            thr2 = int'(thresh_reg) * int'(thresh_reg);

            res.edge_value = (mag2 >= thr2) ? EDGE_CODE : PLAIN_CODE;
            res.frame_last = (cr + 1 == h) && (cc + 1 == w);
            pending_edges.insert(pending_edges.size(), res);
            if (res.frame_last) begin
                col_pos = 0;
                row_pos = 0;
            end
        endfunction

        function void check_result(logic [PIX_W-1:0] edge_value, logic frame_last);
            t_edge_result exp_res;

            seen++;
            if (pending_edges.size() == 0) begin
                flag($sformatf("result %0d arrived with none owed: edge_value %0d tlast %b",
                               seen, edge_value, frame_last));
                return;
            end
            exp_res = pending_edges.pop_front();
            if (edge_value !== exp_res.edge_value || frame_last !== exp_res.frame_last)
                flag($sformatf("result %0d: expected edge_value %0d tlast %b, got %0d %b",
                               seen, exp_res.edge_value, exp_res.frame_last,
                               edge_value, frame_last));
        endfunction

        // Count results still owed as failures and return the failure total.
        function int close();
            if (pending_edges.size() != 0)
                flag($sformatf("%0d results never arrived", pending_edges.size()));
            return errors;
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;
    logic [0:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;
    logic                m_axis_tlast;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_I_W-1:0]  i_cfg_index = '0;
    logic [CFG_D_W-1:0]  i_cfg_data = '0;

    bit tx_burst = 1'b0;   // sender runs without gaps
    bit rx_burst = 1'b0;   // receiver runs without stalls

    edge_scoreboard sb = new();

    sobel_edge_threshold #(.MAX_WIDTH(MAX_W)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Offer one pixel, hold it until the transfer, then hand it to the predictor.
    // With no gap, tvalid stays high and only the payload changes.
    task automatic send_item(input logic [PIX_W-1:0] pix, input logic is_flush);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        s_axis_tuser <= is_flush;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_pixel(pix, is_flush);
    endtask

    // Drop tvalid and hold off until every owed result has come out.
    task automatic pause_until_empty();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Idle point: nothing owed and the pipeline settled, so registers may change.
    task automatic drain();
        pause_until_empty();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_I_W-1:0] idx, input logic [CFG_D_W-1:0] data);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    task automatic cfg_close();
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: stall a random number of cycles per result, then take the
    // next transfer and check it against the oldest prediction.
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            sb.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin : stimulus
        int unsigned w, h, n_items, rand_items;
        int pick;
        bit smooth, well_formed;
        logic [PIX_W-1:0] base, pix;

        rand_items = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values: width 640, threshold 2. Just over one row
        // brings out the first results of row zero; small values keep the
        // gradients near the threshold.
        for (int i = 0; i < 650; i++) send_item(PIX_W'($urandom_range(0, 1)), 1'b0);
        drain();

        // 3x3 frame, threshold zero: every pixel is an edge. Flush items carry
        // arbitrary pixel values that must not matter.
        cfg_write(CFG_WIDTH, 13'd3);
        cfg_write(CFG_HEIGHT, 13'd3);
        cfg_write(CFG_THRESH, 13'd0);
        cfg_close();
        for (int i = 0; i < 9; i++) send_item((i % 2) ? 8'hFF : 8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        send_item(8'hAA, 1'b1);
        send_item(8'h55, 1'b1);
        drain();

        // Single-pixel frame at the top threshold: the only pixel is first and last.
        cfg_write(CFG_WIDTH, 13'd1);
        cfg_write(CFG_HEIGHT, 13'd1);
        cfg_write(CFG_THRESH, 13'd2047);
        cfg_close();
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
        drain();

        // 2x2 frame with a flush item inside the frame; an out-of-range index
        // write must change nothing.
        cfg_write(CFG_WIDTH, 13'd2);
        cfg_write(CFG_HEIGHT, 13'd2);
        cfg_write(CFG_THRESH, 13'd300);
        cfg_write(CFG_UNUSED, 13'h1FFF);
        cfg_close();
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        pause_until_empty();
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        drain();

        // Random phases: new settings, then mostly whole frames with their
        // flush tail, sometimes a cut-off run that the next size write restarts.
        while (rand_items < RANDOM_ITEMS) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);

            if ($urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) w = 0;
                else if (pick == 1) w = $urandom_range(9, 2047);
                else w = $urandom_range(1, 8);
                cfg_write(CFG_WIDTH, CFG_D_W'(($urandom_range(0, 3) << WREG_W) | w));
            end
            if ($urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) h = 0;
                else if (pick == 1) h = $urandom_range(4097, 8191);
                else if (pick == 2) h = HEIGHT_LIMIT;
                else h = $urandom_range(1, 6);
                cfg_write(CFG_HEIGHT, CFG_D_W'(h));
            end
            if ($urandom_range(0, 3) != 0) begin
                pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                   : $urandom_range(0, 500);
                cfg_write(CFG_THRESH, CFG_D_W'(($urandom_range(0, 3) << THR_W) | pick));
            end
            if ($urandom_range(0, 5) == 0)
                cfg_write(CFG_UNUSED, CFG_D_W'($urandom()));
            cfg_close();

            w = sb.used_width();
            h = sb.used_height();
            smooth = ($urandom_range(0, 2) == 0);
            base = PIX_W'($urandom_range(0, 252));
            well_formed = (w * h <= 120) && ($urandom_range(0, 5) != 0);
            n_items = well_formed ? w * h + w + 1 : $urandom_range(1, 60);

            for (int i = 0; i < n_items; i++) begin
                pix = smooth ? base + PIX_W'($urandom_range(0, 3)) : PIX_W'($urandom());
                if ($urandom_range(0, 63) == 0) pause_until_empty();
                if (well_formed)
                    send_item(pix, (i >= w * h) || ($urandom_range(0, 19) == 0));
                else
                    send_item(pix, $urandom_range(0, 3) == 0);
            end
            rand_items += n_items;
            drain();
        end

        if (sb.close() == 0)
            $display("tb_sobel_edge_threshold: PASS");
        else
            $display("tb_sobel_edge_threshold: FAIL");
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin : watchdog
        #4_000_000;
        $display("tb_sobel_edge_threshold: FAIL");
        $finish;
    end

endmodule
